// ===== src/pasc_pkg.sv =====
// ----------------------------------------------------------------------------
// pasc_pkg
// Shared types, codes and defaults for the page address sort/coalesce block.
// ----------------------------------------------------------------------------
package pasc_pkg;

    // Default sizing handed to the top-level parameters
    localparam int CAPACITY_DEF  = 1024;
    localparam int ADDR_BITS_DEF = 48;

    // Fixed field widths
    localparam int UNIQ_W        = 11;
    localparam int STATUS_W      = 2;
    localparam int PG_LOG_W      = 5;
    localparam int RGN_LIM_W     = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_PG_LOG  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RGN_LIM = 1'b1;

    localparam logic [PG_LOG_W-1:0]  PG_LOG_RST  = 5'd12;
    localparam logic [PG_LOG_W-1:0]  PG_LOG_MIN  = 5'd12;
    localparam logic [PG_LOG_W-1:0]  PG_LOG_MAX  = 5'd21;
    localparam logic [RGN_LIM_W-1:0] RGN_LIM_RST = 7'd64;
    localparam logic [RGN_LIM_W-1:0] RGN_LIM_TOP = 7'd64;
    localparam logic [RGN_LIM_W-1:0] RGN_LIM_LOW = 7'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_REGION   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_PAGES = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DROPPED  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        S_COLLECT,
        S_DRAIN,
        S_STATUS,
        S_SCAN
    } state_t;

    // Broadcast control for the cell row
    typedef struct packed {
        logic clear;   // drop every held value and every value in flight
        logic shift;   // move all held values one cell toward the head
    } chain_ctrl_t;

endpackage

// ===== src/page_address_sort_coalesce.sv =====
// ----------------------------------------------------------------------------
// page_address_sort_coalesce
// Collects page addresses, sorts and dedups them in a cell row, and emits
// coalesced page regions.
//
// Addresses are taken one transaction per cycle while collecting and enter
// a row of CAPACITY sorting cells, so the batch is sorted and deduplicated
// while it streams in. The transaction flagged last_item closes the batch.
// If events were dropped, the store overflowed (more than CAPACITY non-short
// records), or no address was collected, one status transaction follows
// (priority: dropped, overflow, no pages). Otherwise the block waits in a
// drain state for the last value to settle through the row, then reads the
// row out from the head cell, one unique page per cycle while the output is
// not stalled, merging consecutive pages into regions. Up to the configured
// region limit of regions go out, the final one with last_region set; every
// one carries the batch's unique page count. The input is stalled from the
// last item until the final result is in the output register. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module page_address_sort_coalesce #(
    parameter int CAPACITY  = pasc_pkg::CAPACITY_DEF,
    parameter int ADDR_BITS = pasc_pkg::ADDR_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [pasc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pasc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ADDR_BITS-1:0]                page_addr,
    input  logic                                short_record,
    input  logic                                ring_dropped,
    input  logic                                last_item,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ADDR_BITS-1:0]                region_start,
    output logic [ADDR_BITS:0]                  region_end,
    output logic [pasc_pkg::UNIQ_W-1:0]         unique_pages,
    output logic [pasc_pkg::STATUS_W-1:0]       status,
    output logic                                last_region
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int END_W = ADDR_BITS + 1;

    // ---------------- configuration registers ----------------
    logic [pasc_pkg::PG_LOG_W-1:0]  pg_log_reg;
    logic [pasc_pkg::RGN_LIM_W-1:0] rgn_lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pg_log_reg  <= pasc_pkg::PG_LOG_RST;
            rgn_lim_reg <= pasc_pkg::RGN_LIM_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pasc_pkg::CFG_PG_LOG:
                    pg_log_reg <= cfg_data[pasc_pkg::PG_LOG_W-1:0];
                pasc_pkg::CFG_RGN_LIM:
                    rgn_lim_reg <= cfg_data;
                default:
                    pg_log_reg <= pg_log_reg;
            endcase
        end
    end

    // Saturated page shift and region limit
    logic [pasc_pkg::PG_LOG_W-1:0]  shift_sat;
    logic [pasc_pkg::RGN_LIM_W-1:0] limit;
    logic [END_W-1:0]               page_step;

    always_comb
    begin
        priority if (pg_log_reg < pasc_pkg::PG_LOG_MIN)
            shift_sat = pasc_pkg::PG_LOG_MIN;
        else if (pg_log_reg > pasc_pkg::PG_LOG_MAX)
            shift_sat = pasc_pkg::PG_LOG_MAX;
        else
            shift_sat = pg_log_reg;

        priority if (rgn_lim_reg == '0)
            limit = pasc_pkg::RGN_LIM_LOW;
        else if (rgn_lim_reg > pasc_pkg::RGN_LIM_TOP)
            limit = pasc_pkg::RGN_LIM_TOP;
        else
            limit = rgn_lim_reg;
    end

    assign page_step = END_W'(1) << shift_sat;

    // ---------------- batch state ----------------
    pasc_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]                  stored_reg, stored_next;   // all stored records
    logic [CNT_W-1:0]                  dups_reg, dups_next;       // duplicates seen at tail
    logic                              ovf_reg, ovf_next;
    logic [CNT_W-1:0]                  drain_reg, drain_next;
    logic [pasc_pkg::UNIQ_W-1:0]       uniq_reg, uniq_next;
    logic [pasc_pkg::STATUS_W-1:0]     stat_reg, stat_next;

    // open region during readout
    logic                              open_reg, open_next;
    logic [ADDR_BITS-1:0]              cur_start_reg, cur_start_next;
    logic [END_W-1:0]                  cur_end_reg, cur_end_next;
    logic [pasc_pkg::RGN_LIM_W-1:0]    nr_reg, nr_next;

    // output register
    logic                              out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0]              rs_reg, rs_next;
    logic [END_W-1:0]                  re_reg, re_next;
    logic [pasc_pkg::UNIQ_W-1:0]       up_reg, up_next;
    logic [pasc_pkg::STATUS_W-1:0]     st_reg, st_next;
    logic                              lr_reg, lr_next;

    // cell row
    pasc_pkg::chain_ctrl_t             chain_ctrl;
    logic                              ins_vld;
    logic                              head_vld;
    logic [ADDR_BITS-1:0]              head_val;
    logic                              tail_dup;

    logic                              in_accept;
    logic                              full;
    logic                              out_free;
    logic                              out_load;
    logic [CNT_W-1:0]                  uniq_diff;
    logic [CNT_W+pasc_pkg::UNIQ_W-1:0] uniq_wide;
    logic [END_W-1:0]                  head_ext;

    assign in_stall  = (state_reg != pasc_pkg::S_COLLECT);
    assign in_accept = in_valid && !in_stall;
    assign full      = (stored_reg == CNT_W'(CAPACITY));
    assign ins_vld   = in_accept && !short_record && !full;
    assign out_free  = !out_valid_reg || !out_stall;
    assign uniq_diff = stored_reg - dups_reg;
    assign uniq_wide = {{pasc_pkg::UNIQ_W{1'b0}}, uniq_diff};
    assign head_ext  = {1'b0, head_val};

    pasc_chain #(
        .CAPACITY  (CAPACITY),
        .ADDR_BITS (ADDR_BITS)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (chain_ctrl),
        .ins_vld  (ins_vld),
        .ins_val  (page_addr),
        .head_vld (head_vld),
        .head_val (head_val),
        .tail_dup (tail_dup)
    );

    always_comb
    begin
        state_next     = state_reg;
        stored_next    = stored_reg;
        dups_next      = dups_reg;
        ovf_next       = ovf_reg;
        drain_next     = drain_reg;
        uniq_next      = uniq_reg;
        stat_next      = stat_reg;
        open_next      = open_reg;
        cur_start_next = cur_start_reg;
        cur_end_next   = cur_end_reg;
        nr_next        = nr_reg;
        chain_ctrl     = '0;
        out_load       = 1'b0;
        rs_next        = rs_reg;
        re_next        = re_reg;
        up_next        = up_reg;
        st_next        = st_reg;
        lr_next        = lr_reg;

        unique case (state_reg)
            pasc_pkg::S_COLLECT:
            begin
                dups_next = dups_reg + CNT_W'(tail_dup);
                if (in_accept)
                begin
                    if (!short_record)
                    begin
                        if (full)
                            ovf_next = 1'b1;
                        else
                            stored_next = stored_reg + CNT_W'(1);
                    end
                    if (last_item)
                    begin
                        if (ring_dropped || ovf_next || (stored_next == '0))
                        begin
                            priority if (ring_dropped)
                                stat_next = pasc_pkg::STAT_DROPPED;
                            else if (ovf_next)
                                stat_next = pasc_pkg::STAT_OVERFLOW;
                            else
                                stat_next = pasc_pkg::STAT_NO_PAGES;
                            chain_ctrl.clear = 1'b1;
                            stored_next      = '0;
                            dups_next        = '0;
                            ovf_next         = 1'b0;
                            state_next       = pasc_pkg::S_STATUS;
                        end
                        else
                        begin
                            drain_next = CNT_W'(CAPACITY);
                            state_next = pasc_pkg::S_DRAIN;
                        end
                    end
                end
            end

            pasc_pkg::S_DRAIN:
            begin
                // let the last value ripple to its cell and duplicates exit
                dups_next = dups_reg + CNT_W'(tail_dup);
                if (drain_reg == '0)
                begin
                    uniq_next   = uniq_wide[pasc_pkg::UNIQ_W-1:0];
                    stored_next = '0;
                    dups_next   = '0;
                    ovf_next    = 1'b0;
                    open_next   = 1'b0;
                    nr_next     = '0;
                    state_next  = pasc_pkg::S_SCAN;
                end
                else
                begin
                    drain_next = drain_reg - CNT_W'(1);
                end
            end

            pasc_pkg::S_STATUS:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    rs_next    = '0;
                    re_next    = '0;
                    up_next    = '0;
                    st_next    = stat_reg;
                    lr_next    = 1'b1;
                    state_next = pasc_pkg::S_COLLECT;
                end
            end

            pasc_pkg::S_SCAN:
            begin
                if (head_vld)
                begin
                    priority if (!open_reg)
                    begin
                        open_next        = 1'b1;
                        cur_start_next   = head_val;
                        cur_end_next     = head_ext + page_step;
                        chain_ctrl.shift = 1'b1;
                    end
                    else if (head_ext == cur_end_reg)
                    begin
                        cur_end_next     = cur_end_reg + page_step;
                        chain_ctrl.shift = 1'b1;
                    end
                    else if (out_free)
                    begin
                        // region break: emit the open region
                        out_load = 1'b1;
                        rs_next  = cur_start_reg;
                        re_next  = cur_end_reg;
                        up_next  = uniq_reg;
                        st_next  = pasc_pkg::STAT_REGION;
                        nr_next  = nr_reg + pasc_pkg::RGN_LIM_W'(1);
                        if (nr_next == limit)
                        begin
                            // limit reached: rest of the batch is dropped
                            lr_next          = 1'b1;
                            chain_ctrl.clear = 1'b1;
                            state_next       = pasc_pkg::S_COLLECT;
                        end
                        else
                        begin
                            lr_next          = 1'b0;
                            cur_start_next   = head_val;
                            cur_end_next     = head_ext + page_step;
                            chain_ctrl.shift = 1'b1;
                        end
                    end
                    else
                    begin
                        open_next = open_reg;
                    end
                end
                else if (out_free)
                begin
                    // row exhausted: close the final region
                    out_load         = 1'b1;
                    rs_next          = cur_start_reg;
                    re_next          = cur_end_reg;
                    up_next          = uniq_reg;
                    st_next          = pasc_pkg::STAT_REGION;
                    lr_next          = 1'b1;
                    chain_ctrl.clear = 1'b1;
                    state_next       = pasc_pkg::S_COLLECT;
                end
            end

            default:
            begin
                state_next = pasc_pkg::S_COLLECT;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pasc_pkg::S_COLLECT;
            stored_reg    <= '0;
            dups_reg      <= '0;
            ovf_reg       <= 1'b0;
            drain_reg     <= '0;
            open_reg      <= 1'b0;
            nr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stored_reg    <= stored_next;
            dups_reg      <= dups_next;
            ovf_reg       <= ovf_next;
            drain_reg     <= drain_next;
            open_reg      <= open_next;
            nr_reg        <= nr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        uniq_reg      <= uniq_next;
        stat_reg      <= stat_next;
        cur_start_reg <= cur_start_next;
        cur_end_reg   <= cur_end_next;
        rs_reg        <= rs_next;
        re_reg        <= re_next;
        up_reg        <= up_next;
        st_reg        <= st_next;
        lr_reg        <= lr_next;
    end

    assign out_valid    = out_valid_reg;
    assign region_start = rs_reg;
    assign region_end   = re_reg;
    assign unique_pages = up_reg;
    assign status       = st_reg;
    assign last_region  = lr_reg;

    // ---------------- assertions ----------------

    // a status transaction always closes its batch
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (st_reg != pasc_pkg::STAT_REGION)) |-> lr_reg)
        else $error("status result without last_region");

    // every region covers at least one page
    a_region_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (st_reg == pasc_pkg::STAT_REGION)) |->
            (re_reg > {1'b0, rs_reg}))
        else $error("region end not above region start");

    // readout from the head cell is strictly ascending
    a_head_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        chain_ctrl.shift |=> (!head_vld || (head_val > $past(head_val))))
        else $error("cell row readout not strictly ascending");

endmodule

// ===== src/pasc_cell.sv =====
// ----------------------------------------------------------------------------
// pasc_cell
// One sorting cell: keeps the smaller value, hands the larger one onward.
// ----------------------------------------------------------------------------
module pasc_cell #(
    parameter int W = pasc_pkg::ADDR_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pasc_pkg::chain_ctrl_t ctrl,
    input  logic                ins_vld,
    input  logic                ins_dup,
    input  logic [W-1:0]        ins_val,
    input  logic                nbr_vld,
    input  logic [W-1:0]        nbr_val,
    output logic                pass_vld,
    output logic                pass_dup,
    output logic [W-1:0]        pass_val,
    output logic                held_vld,
    output logic [W-1:0]        held_val
);

    logic         held_vld_reg, held_vld_next;
    logic [W-1:0] held_val_reg, held_val_next;
    logic         pass_vld_reg, pass_vld_next;
    logic         pass_dup_reg, pass_dup_next;
    logic [W-1:0] pass_val_reg, pass_val_next;

    always_comb
    begin
        held_vld_next = held_vld_reg;
        held_val_next = held_val_reg;
        pass_vld_next = 1'b0;
        pass_dup_next = 1'b0;
        pass_val_next = ins_val;
        priority if (ctrl.clear)
        begin
            held_vld_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            held_vld_next = nbr_vld;
            held_val_next = nbr_val;
        end
        else if (ins_vld)
        begin
            priority if (ins_dup)
            begin
                // duplicate token travels to the tail to be counted
                pass_vld_next = 1'b1;
                pass_dup_next = 1'b1;
            end
            else if (!held_vld_reg)
            begin
                held_vld_next = 1'b1;
                held_val_next = ins_val;
            end
            else if (ins_val < held_val_reg)
            begin
                held_val_next = ins_val;
                pass_vld_next = 1'b1;
                pass_val_next = held_val_reg;
            end
            else if (ins_val == held_val_reg)
            begin
                pass_vld_next = 1'b1;
                pass_dup_next = 1'b1;
            end
            else
            begin
                pass_vld_next = 1'b1;
            end
        end
        else
        begin
            // nothing arriving: keep the held value
            held_vld_next = held_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_vld_reg <= 1'b0;
            pass_vld_reg <= 1'b0;
            pass_dup_reg <= 1'b0;
        end
        else
        begin
            held_vld_reg <= held_vld_next;
            pass_vld_reg <= pass_vld_next;
            pass_dup_reg <= pass_dup_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_val_reg <= held_val_next;
        pass_val_reg <= pass_val_next;
    end

    assign pass_vld = pass_vld_reg;
    assign pass_dup = pass_dup_reg;
    assign pass_val = pass_val_reg;
    assign held_vld = held_vld_reg;
    assign held_val = held_val_reg;

endmodule

// ===== src/pasc_chain.sv =====
// ----------------------------------------------------------------------------
// pasc_chain
// Row of sorting cells; head cell holds the smallest unique value.
// ----------------------------------------------------------------------------
module pasc_chain #(
    parameter int CAPACITY  = pasc_pkg::CAPACITY_DEF,
    parameter int ADDR_BITS = pasc_pkg::ADDR_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pasc_pkg::chain_ctrl_t ctrl,
    input  logic                  ins_vld,
    input  logic [ADDR_BITS-1:0]  ins_val,
    output logic                  head_vld,
    output logic [ADDR_BITS-1:0]  head_val,
    output logic                  tail_dup
);

    logic                 pass_vld [CAPACITY];
    logic                 pass_dup [CAPACITY];
    logic [ADDR_BITS-1:0] pass_val [CAPACITY];
    logic                 held_vld [CAPACITY];
    logic [ADDR_BITS-1:0] held_val [CAPACITY];
    logic                 c_ins_vld [CAPACITY];
    logic                 c_ins_dup [CAPACITY];
    logic [ADDR_BITS-1:0] c_ins_val [CAPACITY];
    logic                 c_nbr_vld [CAPACITY];
    logic [ADDR_BITS-1:0] c_nbr_val [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign c_ins_vld[i] = ins_vld;
            assign c_ins_dup[i] = 1'b0;
            assign c_ins_val[i] = ins_val;
        end
        else
        begin : g_inner
            assign c_ins_vld[i] = pass_vld[i-1];
            assign c_ins_dup[i] = pass_dup[i-1];
            assign c_ins_val[i] = pass_val[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign c_nbr_vld[i] = 1'b0;
            assign c_nbr_val[i] = '0;
        end
        else
        begin : g_mid
            assign c_nbr_vld[i] = held_vld[i+1];
            assign c_nbr_val[i] = held_val[i+1];
        end

        pasc_cell #(
            .W (ADDR_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .ins_vld  (c_ins_vld[i]),
            .ins_dup  (c_ins_dup[i]),
            .ins_val  (c_ins_val[i]),
            .nbr_vld  (c_nbr_vld[i]),
            .nbr_val  (c_nbr_val[i]),
            .pass_vld (pass_vld[i]),
            .pass_dup (pass_dup[i]),
            .pass_val (pass_val[i]),
            .held_vld (held_vld[i]),
            .held_val (held_val[i])
        );
    end

    assign head_vld = held_vld[0];
    assign head_val = held_val[0];
    // only duplicate tokens ever leave the last cell
    assign tail_dup = pass_vld[CAPACITY-1] && pass_dup[CAPACITY-1];

endmodule

// ===== tb/page_address_sort_coalesce_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_address_sort_coalesce_tb
// Self-checking bench for the page address sort/coalesce block.
//
// Batches of page-address records are queued by the stimulus process and fed
// to the block by a valid/stall driver. Every transaction the block accepts
// also goes through a software copy of the batch store. On the last record
// of a batch, that copy sorts, dedups and merges the stored pages into
// the expected regions (or the single status result). A monitor compares
// each result transaction, field by field, against the oldest expected
// entry. Both sides idle and stall at random. One phase holds the output
// off for a long stretch, so the block backs up into its input. Register
// writes happen only while the block is idle, between phases.
// ----------------------------------------------------------------------------
module page_address_sort_coalesce_tb;

    localparam int CAP          = pasc_pkg::CAPACITY_DEF;
    localparam int AW           = pasc_pkg::ADDR_BITS_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LONG_HOLD    = 2500;          // receiver hold-off, in cycles
    localparam int SETTLE_TAIL  = CAP + 200;     // quiet time before the verdict
    localparam int IDLE_PAD     = 20;            // pause before a register write
    localparam int MAX_REPORTS  = 10;

    // One ring record as offered on the input channel
    typedef struct {
        logic [AW-1:0] addr;
        logic          short_rec;
        logic          dropped;
        logic          last_flag;
    } record_t;

    // One result transaction as seen on the output channel
    typedef struct {
        logic [AW-1:0]                 first_addr;
        logic [AW:0]                   past_addr;
        logic [pasc_pkg::UNIQ_W-1:0]   uniq;
        logic [pasc_pkg::STATUS_W-1:0] stat;
        logic                          last_flag;
    } region_t;

    // ------------------------------------------------------------------------
    // Block I/O. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_wr_en    = 1'b0;
    logic [pasc_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [pasc_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                            in_valid     = 1'b0;
    logic                            in_stall;
    logic [AW-1:0]                   page_addr    = '0;
    logic                            short_record = 1'b0;
    logic                            ring_dropped = 1'b0;
    logic                            last_item    = 1'b0;
    logic                            out_valid;
    logic                            out_stall    = 1'b0;
    logic [AW-1:0]                   region_start;
    logic [AW:0]                     region_end;
    logic [pasc_pkg::UNIQ_W-1:0]     unique_pages;
    logic [pasc_pkg::STATUS_W-1:0]   status;
    logic                            last_region;

    page_address_sort_coalesce DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .page_addr    (page_addr),
        .short_record (short_record),
        .ring_dropped (ring_dropped),
        .last_item    (last_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .region_start (region_start),
        .region_end   (region_end),
        .unique_pages (unique_pages),
        .status       (status),
        .last_region  (last_region)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    record_t drain_records[$];       // records still to be offered
    region_t expected_regions[$];    // results predicted, not yet seen

    // Shadow of the block's batch store and registers
    logic [AW-1:0]                  batch_pages [CAP];
    int unsigned                    batch_fill     = 0;
    bit                             batch_overflow = 1'b0;
    logic [pasc_pkg::PG_LOG_W-1:0]  shift_reg      = pasc_pkg::PG_LOG_RST;
    logic [pasc_pkg::RGN_LIM_W-1:0] regions_reg    = pasc_pkg::RGN_LIM_RST;

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  in_accepted    = 1'b0;   // input transaction taken at the last rising edge
    bit  steady         = 1'b0;   // no random idling on either side
    bit  hold_request   = 1'b0;   // ask the receiver for one long hold-off
    bit  hold_done      = 1'b0;
    int  hold_count     = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    bit  stall_on       = 1'b0;

    // 10 ns clock
    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Idle length: mostly none, often short, now and then long
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Page shift as the block applies it: saturated into 12..21
    function automatic int unsigned page_bits();
        if (shift_reg < pasc_pkg::PG_LOG_MIN)
            return pasc_pkg::PG_LOG_MIN;
        if (shift_reg > pasc_pkg::PG_LOG_MAX)
            return pasc_pkg::PG_LOG_MAX;
        return shift_reg;
    endfunction

    // Region cap as the block applies it: zero acts as one, top is 64
    function automatic int unsigned region_cap();
        if (regions_reg < pasc_pkg::RGN_LIM_LOW)
            return pasc_pkg::RGN_LIM_LOW;
        if (regions_reg > pasc_pkg::RGN_LIM_TOP)
            return pasc_pkg::RGN_LIM_TOP;
        return regions_reg;
    endfunction

    function automatic logic [AW-1:0] rand_addr();
        return {16'($urandom()), $urandom()};
    endfunction

    // ------------------------------------------------------------------------
    // Prediction: one accepted record goes into the shadow store; the last
    // record of a batch turns the store into the expected result list.
    // ------------------------------------------------------------------------
    task automatic coalesce_record(input record_t rec);
        logic [AW-1:0] key;
        logic [AW-1:0] run_first;
        logic [AW:0]   run_past;
        logic [AW:0]   page;
        int unsigned   n, uniq, i, j, emitted, limit;
        region_t       res;
        if (!rec.short_rec) begin
            if (batch_fill < CAP) begin
                batch_pages[batch_fill] = rec.addr;
                batch_fill++;
            end
            else
                batch_overflow = 1'b1;
        end
        if (!rec.last_flag)
            return;

        if (rec.dropped || batch_overflow || batch_fill == 0) begin
            // one status transaction; dropped outranks overflow, then empty
            res.first_addr = '0;
            res.past_addr  = '0;
            res.uniq       = '0;
            res.last_flag  = 1'b1;
            if (rec.dropped)
                res.stat = pasc_pkg::STAT_DROPPED;
            else if (batch_overflow)
                res.stat = pasc_pkg::STAT_OVERFLOW;
            else
                res.stat = pasc_pkg::STAT_NO_PAGES;
            expected_regions.push_back(res);
        end
        else begin
            page  = (AW+1)'(1) << page_bits();
            limit = region_cap();
            n     = batch_fill;
            // ascending insertion sort
            for (i = 1; i < n; i++) begin
                key = batch_pages[i];
                j   = i;
                while (j > 0 && batch_pages[j-1] > key) begin
                    batch_pages[j] = batch_pages[j-1];
                    j--;
                end
                batch_pages[j] = key;
            end
            // squeeze out duplicates
            uniq = 1;
            for (i = 1; i < n; i++) begin
                if (batch_pages[i] != batch_pages[uniq-1]) begin
                    batch_pages[uniq] = batch_pages[i];
                    uniq++;
                end
            end
            // merge runs where the next address lands exactly on the run end
            emitted = 0;
            i       = 0;
            while (i < uniq && emitted < limit) begin
                run_first = batch_pages[i];
                run_past  = {1'b0, run_first} + page;
                while (i + 1 < uniq && {1'b0, batch_pages[i+1]} == run_past) begin
                    run_past = run_past + page;
                    i++;
                end
                res.first_addr = run_first;
                res.past_addr  = run_past;
                res.uniq       = pasc_pkg::UNIQ_W'(uniq);
                res.stat       = pasc_pkg::STAT_REGION;
                res.last_flag  = 1'b0;
                expected_regions.push_back(res);
                emitted++;
                i++;
            end
            expected_regions[expected_regions.size()-1].last_flag = 1'b1;
        end
        batch_fill     = 0;
        batch_overflow = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic push_record(input logic [AW-1:0] addr, input logic sh,
                               input logic dr, input logic lst);
        record_t rec;
        rec.addr      = addr;
        rec.short_rec = sh;
        rec.dropped   = dr;
        rec.last_flag = lst;
        drain_records.push_back(rec);
    endtask

    // Hand-picked batches at the reset register values (4 KiB pages, 64 regions)
    task automatic queue_directed();
        // lone page at address zero
        push_record(48'h0000_0000_0000, 1'b0, 1'b0, 1'b1);
        // only a short record: no pages
        push_record(48'h1234_5678_9000, 1'b1, 1'b0, 1'b1);
        // all-ones address, unaligned; region end needs the 49th bit
        push_record(48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b1);
        // top two pages, a duplicate, and a dropped flag that is ignored mid-batch
        push_record(48'hFFFF_FFFF_F000, 1'b0, 1'b1, 1'b0);
        push_record(48'hFFFF_FFFF_E000, 1'b0, 1'b0, 1'b0);
        push_record(48'hFFFF_FFFF_F000, 1'b0, 1'b0, 1'b1);
        // out of order, duplicate, short record in between, gap between runs
        push_record(48'h0000_0000_3000, 1'b0, 1'b0, 1'b0);
        push_record(48'h0000_0000_1000, 1'b0, 1'b0, 1'b0);
        push_record(48'h0000_0000_2000, 1'b0, 1'b0, 1'b0);
        push_record(48'h0000_0000_1000, 1'b0, 1'b0, 1'b0);
        push_record(48'h5555_5555_5000, 1'b1, 1'b0, 1'b0);
        push_record(48'h0000_0000_5000, 1'b0, 1'b0, 1'b1);
        // unaligned addresses still chain on an exact match
        push_record(48'h0000_0000_1234, 1'b0, 1'b0, 1'b0);
        push_record(48'h0000_0000_2234, 1'b0, 1'b0, 1'b1);
        // dropped events on the last record
        push_record(48'h0000_0000_7000, 1'b0, 1'b0, 1'b0);
        push_record(48'h0000_0000_8000, 1'b0, 1'b1, 1'b1);
        // dropped outranks an empty batch
        push_record(48'hAAAA_AAAA_A000, 1'b1, 1'b1, 1'b1);
        // duplicates only
        push_record(48'h0000_0000_9000, 1'b0, 1'b0, 1'b0);
        push_record(48'h0000_0000_9000, 1'b0, 1'b0, 1'b1);
    endtask

    // A batch with more regions than the cap, at the reset register values
    task automatic queue_cap_batch();
        int k;
        // 70 separate pages, so the region cap of 64 cuts the list
        for (k = 0; k < 70; k++)
            push_record(48'h0010_0000_0000 + AW'((69 - k) * 2) * 48'h1000,
                        1'b0, 1'b0, k == 69);
    endtask

    // One random batch; 'counted' is the number of records the block acts on
    task automatic queue_random_batch(output int counted);
        int            kind, n, k, span;
        int unsigned   sh_bits;
        logic [AW-1:0] base;
        logic [AW:0]   offs;
        logic          sh, dr, lst;
        sh_bits = page_bits();
        kind    = $urandom_range(0, 99);
        counted = 0;
        if (kind < 8) begin
            // nothing but short records
            n = $urandom_range(0, 3);
            repeat (n) push_record(rand_addr(), 1'b1, 1'($urandom_range(0, 1)), 1'b0);
            push_record(rand_addr(), 1'b1, 1'b0, 1'b1);
            counted = 1;
        end
        else if (kind < 22) begin
            // noise: full-range addresses, random flags
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++) begin
                sh  = ($urandom_range(0, 3) == 0);
                lst = (k == n - 1);
                dr  = lst ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
                push_record(rand_addr(), sh, dr, lst);
                if (!sh || lst)
                    counted++;
            end
        end
        else begin
            // well-formed batch: pages clustered around one base, with holes,
            // duplicates and the odd short record, so runs actually form
            n    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80)
                                               : $urandom_range(1, 16);
            span = n + $urandom_range(0, n + 2);
            base = rand_addr();
            case ($urandom_range(0, 9))
                0:       ;                                  // left unaligned
                1, 2:    base[11:0] = '0;                   // 4 KiB aligned only
                default: base = (base >> sh_bits) << sh_bits;
            endcase
            if ($urandom_range(0, 7) == 0)
                base[AW-1:AW-8] = 8'hFF;                    // near the top
            for (k = 0; k < n; k++) begin
                lst  = (k == n - 1);
                offs = (AW+1)'($urandom_range(0, span - 1)) << sh_bits;
                sh   = lst ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 9) == 0);
                dr   = lst ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 4) == 0);
                push_record(base + offs[AW-1:0], sh, dr, lst);
                if (!sh || lst)
                    counted++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Phase control
    // ------------------------------------------------------------------------

    // Block idle: nothing left to send, nothing in flight, nothing owed
    task automatic wait_idle();
        while (drain_records.size() != 0 || in_valid || expected_regions.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pasc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pasc_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == pasc_pkg::CFG_PG_LOG)
            shift_reg = val[pasc_pkg::PG_LOG_W-1:0];
        else
            regions_reg = val[pasc_pkg::RGN_LIM_W-1:0];
    endtask

    task automatic run_phase(input logic [pasc_pkg::CFG_DATA_W-1:0] shift_val,
                             input logic [pasc_pkg::CFG_DATA_W-1:0] regions_val,
                             input int target, input bit quiet);
        int got, c;
        wait_idle();
        write_reg(pasc_pkg::CFG_PG_LOG, shift_val);
        write_reg(pasc_pkg::CFG_RGN_LIM, regions_val);
        steady = quiet;
        got    = 0;
        while (got < target) begin
            queue_random_batch(c);
            got += c;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        int k, b;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_directed();
        queue_cap_batch();

        // register settings, extremes and out-of-range values among them
        run_phase(7'd21,  7'd1,   8, 1'b0);
        run_phase(7'd0,   7'd0,   8, 1'b0);   // saturates to 12 / 1
        run_phase(7'd127, 7'd127, 8, 1'b0);   // shift field sees 31 -> 21; cap 64
        run_phase(7'd16,  7'd5,   8, 1'b1);   // no idling in this one
        run_phase(7'd13,  7'd64,  8, 1'b0);
        run_phase(7'd11,  7'd65,  8, 1'b0);
        run_phase(7'd22,  7'd2,   8, 1'b0);

        // Back-pressure: the receiver holds off while the sender keeps
        // offering batches of many regions; the block must stall its input.
        run_phase(7'd12, 7'd64, 0, 1'b1);
        hold_request = 1'b1;
        for (b = 0; b < 3; b++)
            for (k = 0; k < 16; k++)
                push_record(48'h0030_0000_0000 + AW'(b) * 48'h100_0000
                            + AW'(k * 2) * 48'h1000, 1'b0, 1'b0, k == 15);

        wait_idle();
        steady = 1'b0;
        repeat (SETTLE_TAIL) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: presents queued records on the falling edge; a record stays put
    // until it is accepted, then an optional idle gap follows.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        record_t rec;
        if (rst_n) begin
            if (!in_valid || in_accepted) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (drain_records.size() > 0) begin
                    rec = drain_records.pop_front();
                    page_addr    <= rec.addr;
                    short_record <= rec.short_rec;
                    ring_dropped <= rec.dropped;
                    last_item    <= rec.last_flag;
                    in_valid     <= 1'b1;
                    gap_left = steady ? 0 : idle_length();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall: random runs, plus the one long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_request && !hold_done) begin
                out_stall <= 1'b1;
                hold_count++;
                if (hold_count >= LONG_HOLD)
                    hold_done = 1'b1;
            end
            else begin
                if (stall_left == 0) begin
                    stall_on   = ($urandom_range(0, 99) < 30);
                    stall_left = idle_length() + 1;
                end
                stall_left--;
                out_stall <= stall_on && !steady;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: on the rising edge, feed accepted input transactions to the
    // predictor and check accepted result transactions in order.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        record_t rec;
        region_t want;
        if (!rst_n)
            in_accepted <= 1'b0;
        else begin
            in_accepted <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                rec.addr      = page_addr;
                rec.short_rec = short_record;
                rec.dropped   = ring_dropped;
                rec.last_flag = last_item;
                coalesce_record(rec);
            end
            if (out_valid && !out_stall) begin
                if (expected_regions.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result: start %h end %h pages %0d st %0d",
                                 $realtime, region_start, region_end, unique_pages, status);
                end
                else begin
                    want = expected_regions.pop_front();
                    if (region_start !== want.first_addr || region_end !== want.past_addr
                        || unique_pages !== want.uniq || status !== want.stat
                        || last_region !== want.last_flag) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  got  start %h end %h pages %0d st %0d last %0d",
                                     region_start, region_end, unique_pages, status,
                                     last_region);
                            $display("  want start %h end %h pages %0d st %0d last %0d",
                                     want.first_addr, want.past_addr, want.uniq, want.stat,
                                     want.last_flag);
                        end
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
